[design/reuse_distance_histogram_core_defines.svh]
// assertion macros for the reuse distance histogram core
`ifndef REUSE_DISTANCE_HISTOGRAM_CORE_DEFINES_SVH
`define REUSE_DISTANCE_HISTOGRAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define RDH_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rdh assertion failed");

`define RDH_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rdh assertion failed");

`else

`define RDH_ASSERT_IMP(name, clk, rstn, ante, cons)

`define RDH_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

[design/rdh_pkg.sv]
// shared types and constants for the reuse distance histogram core
`timescale 1ns / 1ps

package rdh_pkg;

    localparam int COLUMN_W     = 15;
    localparam int BUCKET_OUT_W = 5;
    localparam int TOTAL_W      = 32;

    // reciprocal multiply for division by a constant
    localparam int DIV_SHIFT = 16;
    localparam int RECIP_W   = DIV_SHIFT + 1;

    // run tags kept with every line entry
    localparam int EPOCH_W = 8;
    typedef logic [EPOCH_W-1:0] epoch_t;
    localparam epoch_t EPOCH_NONE  = '0;
    localparam epoch_t EPOCH_FIRST = epoch_t'(1);
    localparam epoch_t EPOCH_LAST  = '1;

    typedef struct packed {
        logic                new_run;
        logic [COLUMN_W-1:0] column_index;
    } in_item_t;

    typedef struct packed {
        logic                    first_touch;
        logic [BUCKET_OUT_W-1:0] bucket;
        logic [TOTAL_W-1:0]      bucket_total;
        logic [TOTAL_W-1:0]      first_touch_total;
        logic [TOTAL_W-1:0]      access_total;
    } out_item_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic sweep_start;
    } ltab_ctrl_t;

    typedef struct packed {
        logic rd_en;
        logic clear;
        logic wr_en;
    } btab_ctrl_t;

endpackage

[design/rdh_line_index.sv]
// column to line table address: divide by line width, then wrap to table depth
`timescale 1ns / 1ps

module rdh_line_index #(
    parameter int COLUMNS_PER_LINE = 8,
    parameter int LINE_ENTRIES     = 4096,
    parameter int ADDR_W           = 12
) (
    input  logic                         aclk,
    input  logic [3:0]                   load,
    input  logic [rdh_pkg::COLUMN_W-1:0] column_index,
    output logic [ADDR_W-1:0]            line_addr
);
    import rdh_pkg::*;

    localparam int PROD_W = COLUMN_W + RECIP_W;
    localparam int LE_W   = $clog2(LINE_ENTRIES + 1);
    localparam int MOD_W  = (LE_W > COLUMN_W) ? LE_W : COLUMN_W;
    localparam logic [RECIP_W-1:0] COL_RECIP  = RECIP_W'((2 ** DIV_SHIFT) / COLUMNS_PER_LINE);
    localparam logic [RECIP_W-1:0] LINE_RECIP = RECIP_W'((2 ** DIV_SHIFT) / LINE_ENTRIES);

    logic [PROD_W-1:0]   prod1_reg;
    logic [COLUMN_W-1:0] col1_reg;
    logic [COLUMN_W-1:0] line2_reg;
    logic [PROD_W-1:0]   prod3_reg;
    logic [COLUMN_W-1:0] line3_reg;
    logic [ADDR_W-1:0]   addr4_reg;

    logic [COLUMN_W-1:0] q1;
    logic [COLUMN_W-1:0] r1;
    logic [COLUMN_W-1:0] line_next;
    logic [COLUMN_W-1:0] q2;
    logic [COLUMN_W-1:0] r2;
    logic                wrap_ge;
    logic [ADDR_W-1:0]   addr_next;

    // estimates are low by at most one, so one compare corrects them
    always_comb begin
        q1        = prod1_reg[DIV_SHIFT +: COLUMN_W];
        r1        = col1_reg - COLUMN_W'(q1 * COLUMNS_PER_LINE);
        line_next = (r1 >= COLUMN_W'(COLUMNS_PER_LINE)) ? q1 + 1'b1 : q1;

        q2        = prod3_reg[DIV_SHIFT +: COLUMN_W];
        r2        = line3_reg - COLUMN_W'(q2 * LINE_ENTRIES);
        wrap_ge   = MOD_W'(r2) >= MOD_W'(LINE_ENTRIES);
        addr_next = ADDR_W'(wrap_ge ? r2 - COLUMN_W'(LINE_ENTRIES) : r2);
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            prod1_reg <= PROD_W'(column_index) * PROD_W'(COL_RECIP);
            col1_reg  <= column_index;
        end
        if (load[1]) begin
            line2_reg <= line_next;
        end
        if (load[2]) begin
            prod3_reg <= PROD_W'(line2_reg) * PROD_W'(LINE_RECIP);
            line3_reg <= line2_reg;
        end
        if (load[3]) begin
            addr4_reg <= addr_next;
        end
    end

    assign line_addr = addr4_reg;

endmodule

[design/rdh_line_table.sv]
// per-line table of run tag and last touch time, with write-back forwarding and clearing sweep
`timescale 1ns / 1ps

module rdh_line_table #(
    parameter int LINE_ENTRIES = 4096,
    parameter int ADDR_W       = 12,
    parameter int TIME_W       = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rdh_pkg::ltab_ctrl_t ctrl,
    input  logic [ADDR_W-1:0]   rd_addr,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  rdh_pkg::epoch_t     wr_epoch,
    input  logic [TIME_W-1:0]   wr_time,
    output rdh_pkg::epoch_t     rd_epoch,
    output logic [TIME_W-1:0]   rd_time,
    output logic                sweep_busy
);
    import rdh_pkg::*;

    typedef struct packed {
        epoch_t            epoch;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    entry_t mem [LINE_ENTRIES];

    entry_t            wr_entry;
    entry_t            rd_entry;
    entry_t            rdata_reg;
    entry_t            fwd_data_reg;
    logic              fwd_reg;
    logic              sweep_busy_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;

    assign wr_entry = '{epoch: wr_epoch, stamp: wr_time};

    always_ff @(posedge aclk) begin
        if (sweep_busy_reg) begin
            mem[sweep_cnt_reg] <= '{epoch: EPOCH_NONE, stamp: '0};
        end else if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (ctrl.rd_en) begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg        <= 1'b0;
            sweep_busy_reg <= 1'b1;
            sweep_cnt_reg  <= '0;
        end else begin
            // the write landing on the same edge as the read is not seen by the array read
            if (ctrl.rd_en) begin
                fwd_reg <= ctrl.wr_en && (wr_addr == rd_addr);
            end
            if (sweep_busy_reg) begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == ADDR_W'(LINE_ENTRIES - 1)) begin
                    sweep_busy_reg <= 1'b0;
                end
            end else if (ctrl.sweep_start) begin
                sweep_busy_reg <= 1'b1;
                sweep_cnt_reg  <= '0;
            end
        end
    end

    assign rd_entry   = fwd_reg ? fwd_data_reg : rdata_reg;
    assign rd_epoch   = rd_entry.epoch;
    assign rd_time    = rd_entry.stamp;
    assign sweep_busy = sweep_busy_reg;

endmodule

[design/rdh_bucket_table.sv]
// distance bucket counters: memory with per-entry valid bits and write-back forwarding
`timescale 1ns / 1ps

module rdh_bucket_table #(
    parameter int BUCKET_COUNT = 32,
    parameter int BKT_W        = 5,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rdh_pkg::btab_ctrl_t    ctrl,
    input  logic [BKT_W-1:0]       rd_idx,
    input  logic [BKT_W-1:0]       wr_idx,
    input  logic [COUNT_WIDTH-1:0] wr_count,
    output logic [COUNT_WIDTH-1:0] rd_count
);
    import rdh_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [BUCKET_COUNT];

    logic [COUNT_WIDTH-1:0]  rdata_reg;
    logic [COUNT_WIDTH-1:0]  fwd_data_reg;
    logic                    fwd_reg;
    logic                    hit_valid_reg;
    logic [BUCKET_COUNT-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_idx] <= wr_count;
        end
        if (ctrl.rd_en) begin
            rdata_reg    <= mem[rd_idx];
            fwd_data_reg <= wr_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            fwd_reg       <= 1'b0;
            hit_valid_reg <= 1'b0;
        end else begin
            if (ctrl.rd_en) begin
                fwd_reg       <= ctrl.wr_en && (wr_idx == rd_idx) && !ctrl.clear;
                hit_valid_reg <= valid_reg[rd_idx] && !ctrl.clear;
            end
            // a run start wins over the last write of the previous run
            if (ctrl.clear) begin
                valid_reg <= '0;
            end else if (ctrl.wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    assign rd_count = fwd_reg ? fwd_data_reg : (hit_valid_reg ? rdata_reg : '0);

endmodule

[design/reuse_distance_histogram_core.sv]
// reuse distance histogram core: address pipeline, line table, bucket counters, output register
// throughput: one access per cycle unless m_ready is low, a sweep runs or a run tag wrap
//   holds the input; each table is a registered-read memory updated in place, with the
//   write of the item ahead forwarded to the read of the item behind
// reset: a sweep marks every line unseen with s_ready low; it runs again when run tags wrap:
//   at the 255th new_run after reset, then every 254th, once drained
`timescale 1ns / 1ps
`include "reuse_distance_histogram_core_defines.svh"

module reuse_distance_histogram_core #(
    parameter int LINE_ENTRIES     = 4096,
    parameter int COLUMNS_PER_LINE = 8,
    parameter int BUCKET_COUNT     = 32,
    parameter int COUNT_WIDTH      = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rdh_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rdh_pkg::out_item_t m_item
);
    import rdh_pkg::*;

    localparam int ADDR_W = (LINE_ENTRIES > 1) ? $clog2(LINE_ENTRIES) : 1;
    localparam int BKT_W  = $clog2(BUCKET_COUNT);
    localparam int BL_W   = $clog2(COUNT_WIDTH + 1);
    localparam int STAGES = 8;
    localparam int ST_RD  = 3;
    localparam int ST_EX  = 4;
    localparam int ST_BK  = 5;
    localparam int ST_UP  = 6;
    localparam int ST_OUT = 7;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // pipeline control
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] load;
    logic              s_accept;
    logic              wrap_block;
    logic              sweep_busy;
    epoch_t            epoch_reg;
    epoch_t            item_epoch;

    // sideband travelling with each access
    logic [ST_BK:0]    nr_reg;
    epoch_t            ep_reg [ST_EX+1];

    // line table stage
    ltab_ctrl_t             lt_ctrl;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      ex_addr_reg;
    epoch_t                 rd_epoch;
    logic [COUNT_WIDTH-1:0] rd_time;
    logic [COUNT_WIDTH-1:0] time_reg;
    logic [COUNT_WIDTH-1:0] ftc_reg;
    logic [COUNT_WIDTH-1:0] now;
    logic [COUNT_WIDTH-1:0] distance;
    logic [COUNT_WIDTH-1:0] ft_base;
    logic [COUNT_WIDTH-1:0] ft_count;
    logic [COUNT_WIDTH-1:0] time_inc;
    logic                   seen;

    // bucket select stage
    logic                   bk_seen_reg;
    logic [COUNT_WIDTH-1:0] bk_dist_reg;
    logic [COUNT_WIDTH-1:0] bk_ftc_reg;
    logic [COUNT_WIDTH-1:0] bk_time_reg;
    logic [BL_W-1:0]        bit_len;
    logic [BKT_W-1:0]       bucket_idx;

    // bucket update stage
    btab_ctrl_t             bt_ctrl;
    logic                   up_seen_reg;
    logic [BKT_W-1:0]       up_idx_reg;
    logic [COUNT_WIDTH-1:0] up_ftc_reg;
    logic [COUNT_WIDTH-1:0] up_time_reg;
    logic [COUNT_WIDTH-1:0] bt_rd_count;
    logic [COUNT_WIDTH-1:0] count_new;

    out_item_t out_reg;

    // a stage takes a new item when it is empty or its item moves on
    always_comb begin
        load[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign item_epoch = s_item.new_run ? epoch_t'(epoch_reg + 1'b1) : epoch_reg;
    assign wrap_block = s_item.new_run && (epoch_reg == EPOCH_LAST);
    assign s_ready    = load[0] && !sweep_busy && !wrap_block;
    assign s_accept   = s_valid && s_ready;

    assign lt_ctrl.rd_en       = valid_reg[ST_RD] && load[ST_EX];
    assign lt_ctrl.wr_en       = valid_reg[ST_EX] && load[ST_BK];
    assign lt_ctrl.sweep_start = s_valid && wrap_block && !sweep_busy && !(|valid_reg[ST_EX:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            epoch_reg <= EPOCH_FIRST;
            time_reg  <= '0;
            ftc_reg   <= '0;
        end else begin
            if (load[0]) begin
                valid_reg[0] <= s_accept;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (lt_ctrl.sweep_start) begin
                epoch_reg <= EPOCH_FIRST;
            end else if (s_accept) begin
                epoch_reg <= item_epoch;
            end
            if (lt_ctrl.wr_en) begin
                time_reg <= time_inc;
                ftc_reg  <= ft_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            nr_reg[0] <= s_item.new_run;
            ep_reg[0] <= item_epoch;
        end
        for (int k = 1; k <= ST_BK; k++) begin
            if (load[k]) begin
                nr_reg[k] <= nr_reg[k-1];
            end
        end
        for (int k = 1; k <= ST_EX; k++) begin
            if (load[k]) begin
                ep_reg[k] <= ep_reg[k-1];
            end
        end
        if (load[ST_EX]) begin
            ex_addr_reg <= rd_addr;
        end
    end

    rdh_line_index #(
        .COLUMNS_PER_LINE (COLUMNS_PER_LINE),
        .LINE_ENTRIES     (LINE_ENTRIES),
        .ADDR_W           (ADDR_W)
    ) u_index (
        .aclk         (aclk),
        .load         (load[ST_RD:0]),
        .column_index (s_item.column_index),
        .line_addr    (rd_addr)
    );

    rdh_line_table #(
        .LINE_ENTRIES (LINE_ENTRIES),
        .ADDR_W       (ADDR_W),
        .TIME_W       (COUNT_WIDTH)
    ) u_line_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (lt_ctrl),
        .rd_addr    (rd_addr),
        .wr_addr    (ex_addr_reg),
        .wr_epoch   (ep_reg[ST_EX]),
        .wr_time    (now),
        .rd_epoch   (rd_epoch),
        .rd_time    (rd_time),
        .sweep_busy (sweep_busy)
    );

    // a line counts as seen only when tagged with the current run
    always_comb begin
        now      = nr_reg[ST_EX] ? '0 : time_reg;
        seen     = (rd_epoch == ep_reg[ST_EX]);
        distance = (now > rd_time) ? now - rd_time - 1'b1 : '0;
        ft_base  = nr_reg[ST_EX] ? '0 : ftc_reg;
        ft_count = seen ? ft_base : sat_inc(ft_base);
        time_inc = sat_inc(now);
    end

    always_ff @(posedge aclk) begin
        if (load[ST_BK]) begin
            bk_seen_reg <= seen;
            bk_dist_reg <= distance;
            bk_ftc_reg  <= ft_count;
            bk_time_reg <= time_inc;
        end
    end

    // bucket is the bit length of the distance, held at the top bucket; first touches take bucket 0
    always_comb begin
        bit_len = '0;
        for (int i = 0; i < COUNT_WIDTH; i++) begin
            if (bk_dist_reg[i]) begin
                bit_len = BL_W'(i + 1);
            end
        end
        if (!bk_seen_reg) begin
            bucket_idx = '0;
        end else if (8'(bit_len) >= 8'(BUCKET_COUNT - 1)) begin
            bucket_idx = BKT_W'(BUCKET_COUNT - 1);
        end else begin
            bucket_idx = BKT_W'(bit_len);
        end
    end

    assign bt_ctrl.rd_en = valid_reg[ST_BK] && load[ST_UP];
    assign bt_ctrl.clear = bt_ctrl.rd_en && nr_reg[ST_BK];
    assign bt_ctrl.wr_en = valid_reg[ST_UP] && load[ST_OUT] && up_seen_reg;

    always_ff @(posedge aclk) begin
        if (load[ST_UP]) begin
            up_seen_reg <= bk_seen_reg;
            up_idx_reg  <= bucket_idx;
            up_ftc_reg  <= bk_ftc_reg;
            up_time_reg <= bk_time_reg;
        end
    end

    rdh_bucket_table #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .BKT_W        (BKT_W),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_bucket_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (bt_ctrl),
        .rd_idx   (bucket_idx),
        .wr_idx   (up_idx_reg),
        .wr_count (count_new),
        .rd_count (bt_rd_count)
    );

    assign count_new = sat_inc(bt_rd_count);

    always_ff @(posedge aclk) begin
        if (load[ST_OUT]) begin
            out_reg.first_touch       <= !up_seen_reg;
            out_reg.bucket            <= BUCKET_OUT_W'(up_idx_reg);
            out_reg.bucket_total      <= up_seen_reg ? TOTAL_W'(count_new) : '0;
            out_reg.first_touch_total <= TOTAL_W'(up_ftc_reg);
            out_reg.access_total      <= TOTAL_W'(up_time_reg);
        end
    end

    assign m_valid = valid_reg[ST_OUT];
    assign m_item  = out_reg;

    `RDH_ASSERT_IMP(a_sweep_owns_table, aclk, aresetn, sweep_busy, !lt_ctrl.rd_en && !lt_ctrl.wr_en)
    `RDH_ASSERT_NXT(a_sweep_follows_start, aclk, aresetn, lt_ctrl.sweep_start, sweep_busy)
    `RDH_ASSERT_IMP(a_live_epoch, aclk, aresetn, valid_reg[ST_EX], ep_reg[ST_EX] != EPOCH_NONE)
    `RDH_ASSERT_IMP(a_first_touch_no_bucket, aclk, aresetn, m_valid && m_item.first_touch, m_item.bucket == '0 && m_item.bucket_total == '0)

endmodule
